FILE: sv/idsa_pkg.sv
// ----------------------------------------------------------------------------
// idsa_pkg
// shared constants, codes and control types for the id slot allocator
// ----------------------------------------------------------------------------
package idsa_pkg;

  // slot pool size; the 3-bit slot and 4-bit free count fields follow from it
  localparam int SLOTS  = 8;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int KEY_W  = 64;
  localparam int OP_W   = 2;
  localparam int STAT_W = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_FOUND    = 3'd0;
  localparam logic [STAT_W-1:0] ST_NEW      = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOFREE   = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_RELEASED = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture the input beat
    logic exec;  // run the operation and load the result register
  } idsa_cmd_t;

endpackage

FILE: sv/id_slot_allocator.sv
// an input beat is first captured, then run through lookup/update into the result register
// one operation at a time: the next beat is held off until the captured one has run
// the lookup/update step waits while a previous result is stalled at the output
// a new input beat is taken while an earlier result still waits to be taken
// reset: synchronous; all slots free, slot 0 on top of the stack, no key bound
// ----------------------------------------------------------------------------
// id_slot_allocator
// binds 64-bit external identifiers to a small pool of internal slots using a
// key table with valid marks and a lifo free stack
// ----------------------------------------------------------------------------
module id_slot_allocator (
  input  logic                                clk,
  input  logic                                rst,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [idsa_pkg::OP_W-1:0]           operation,
  input  logic [idsa_pkg::KEY_W-1:0]          external_id,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [idsa_pkg::SLOT_W-1:0]         slot,
  output logic [idsa_pkg::STAT_W-1:0]         status,
  output logic [idsa_pkg::CNT_W-1:0]          free_slots
);
  import idsa_pkg::*;

  // commands from the sequencer to the datapath
  idsa_cmd_t cmd;

  // sequencer: holds off the input while a beat is in flight and owns
  // the output valid flag
  idsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // datapath: input capture, eight-way key compare, stack pop/push and
  // the result register that drives the output fields
  idsa_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .operation   (operation),
    .external_id (external_id),
    .slot        (slot),
    .status      (status),
    .free_slots  (free_slots)
  );

endmodule

FILE: sv/idsa_ctrl.sv
// ----------------------------------------------------------------------------
// idsa_ctrl
// sequencer: takes one input beat, runs it once the result register is free
// ----------------------------------------------------------------------------
module idsa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output idsa_pkg::idsa_cmd_t cmd
);
  import idsa_pkg::*;

  typedef enum logic [1:0] {
    S_WAIT = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   out_free;

  // result register empty, or emptied at this edge
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_WAIT);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && out_stall;
    unique case (state)
      S_WAIT: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.exec       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_WAIT;
        end
      end
      default: begin
        state_next = S_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_WAIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // a run never overwrites a result that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |-> !(out_valid && out_stall))
    else $error("result register overwritten while stalled");

  a_exec_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid)
    else $error("run did not present a result");

  a_load_then_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_EXEC && in_stall))
    else $error("captured beat not held for execution");

endmodule

FILE: sv/idsa_dpath.sv
// ----------------------------------------------------------------------------
// idsa_dpath
// key table with valid marks, lifo free stack, lookup and update logic
// ----------------------------------------------------------------------------
module idsa_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  idsa_pkg::idsa_cmd_t                 cmd,
  input  logic [idsa_pkg::OP_W-1:0]           operation,
  input  logic [idsa_pkg::KEY_W-1:0]          external_id,
  output logic [idsa_pkg::SLOT_W-1:0]         slot,
  output logic [idsa_pkg::STAT_W-1:0]         status,
  output logic [idsa_pkg::CNT_W-1:0]          free_slots
);
  import idsa_pkg::*;

  // captured input beat
  logic [OP_W-1:0]   op_q;
  logic [KEY_W-1:0]  id_q;

  // allocator state
  logic [KEY_W-1:0]  key_table  [SLOTS];
  logic [SLOTS-1:0]  slot_valid;
  logic [SLOT_W-1:0] free_stack [SLOTS];
  logic [CNT_W-1:0]  free_count;

  // lookup and decision
  logic              hit_found;
  logic [SLOT_W-1:0] hit_idx;
  logic              hit_on_stack;
  logic [CNT_W-1:0]  cnt_m1;
  logic [SLOT_W-1:0] pop_slot;
  logic [CNT_W-1:0]  cnt_next;
  logic [SLOT_W-1:0] res_slot;
  logic [STAT_W-1:0] res_status;
  logic              do_bind;
  logic              do_unbind;
  logic              do_push;

  // parallel key compare, lowest matching slot wins
  always_comb begin
    hit_found = 1'b0;
    hit_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && key_table[i] == id_q) begin
        hit_found = 1'b1;
        hit_idx   = SLOT_W'(i);
      end
    end
  end

  // is the hit slot already among the live stack entries
  always_comb begin
    hit_on_stack = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (CNT_W'(i) < free_count && free_stack[i] == hit_idx) begin
        hit_on_stack = 1'b1;
      end
    end
  end

  assign cnt_m1   = free_count - CNT_W'(1);
  assign pop_slot = free_stack[cnt_m1[SLOT_W-1:0]];

  always_comb begin
    cnt_next   = free_count;
    res_slot   = '0;
    res_status = ST_NOTFOUND;
    do_bind    = 1'b0;
    do_unbind  = 1'b0;
    do_push    = 1'b0;
    unique case (op_q)
      OP_ALLOC: begin
        if (hit_found) begin
          res_slot   = hit_idx;
          res_status = ST_FOUND;
        end else if (free_count == '0 || free_count > CNT_W'(SLOTS)) begin
          res_status = ST_NOFREE;
        end else begin
          cnt_next   = cnt_m1;
          res_slot   = pop_slot;
          res_status = ST_NEW;
          do_bind    = 1'b1;
        end
      end
      OP_RELEASE: begin
        if (hit_found) begin
          res_slot   = hit_idx;
          res_status = ST_RELEASED;
          do_unbind  = 1'b1;
          if (!hit_on_stack && free_count < CNT_W'(SLOTS)) begin
            do_push  = 1'b1;
            cnt_next = free_count + CNT_W'(1);
          end
        end
      end
      default: begin
        // lookup, and the unused code behaves the same
        if (hit_found) begin
          res_slot   = hit_idx;
          res_status = ST_FOUND;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q <= operation;
      id_q <= external_id;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && do_bind) begin
      key_table[pop_slot] <= id_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      free_count <= CNT_W'(SLOTS);
      for (int i = 0; i < SLOTS; i++) begin
        free_stack[i] <= SLOT_W'(SLOTS - 1 - i);
      end
    end else if (cmd.exec) begin
      free_count <= cnt_next;
      if (do_bind) begin
        slot_valid[pop_slot] <= 1'b1;
      end
      if (do_unbind) begin
        slot_valid[hit_idx] <= 1'b0;
      end
      if (do_push) begin
        free_stack[free_count[SLOT_W-1:0]] <= hit_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      slot       <= res_slot;
      status     <= res_status;
      free_slots <= cnt_next;
    end
  end

  // every slot is either bound or on the free stack
  a_conserve: assert property (@(posedge clk) disable iff (rst)
    ($countones(slot_valid) + int'(free_count)) == SLOTS)
    else $error("bound slots and free slots do not add up");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> ((status != ST_NOFREE && status != ST_NOTFOUND) || slot == '0))
    else $error("failed operation reported a nonzero slot");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.exec |=> $stable(free_count))
    else $error("free count moved without a run");

endmodule
